### design/spc_pkg.sv
package spc_pkg;

    localparam int unsigned COACH_W       = 11;
    localparam int unsigned NEXT_W        = COACH_W + 1;
    localparam int unsigned MAX_ITEMS_DEF = 1024;
    localparam int unsigned S_TDATA_W     = 16;
    localparam int unsigned M_TDATA_W     = 8;

    localparam logic [COACH_W-1:0] COACH_COUNT_RST = COACH_W'(1024);

    // controller -> datapath, at most one command per cycle
    typedef struct packed {
        logic load_item;
        logic fail;
        logic pop;
        logic push;
        logic set_next;
        logic refill;
        logic finish;
    } spc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;
        logic failed;
        logic out_of_range;
        logic top_hit;
        logic next_le_v;
        logic next_lt_v;
        logic push_final;
        logic stack_full;
        logic fill_ge2;
        logic out_free;
    } spc_sts_t;

endpackage

### design/stack_permutation_checker_top.sv
// Each beat is accepted in IDLE and evaluated in EVAL, then takes a PUSH step for each item pushed onto
// the stack, and a REFILL step to reload the top from the registered stack memory read after a pop of depth >= 2.
// A last beat then registers the verdict in FINISH, and waits there while the previous one is unread.
// A new request is taken only in IDLE, so s_tready stays low until the previous request is through.
// Reset (aresetn low, synchronous): count = 1024, sequence state cleared, no result pending.
module stack_permutation_checker_top
    import spc_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [COACH_W-1:0]   cfg_wr_data,   // coach_count
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // [10:0] coach, rest zero
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata        // [0] feasible, rest zero
);

    spc_cmd_t cmd;
    spc_sts_t sts;
    logic     feasible;

    spc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spc_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .coach       (s_tdata[COACH_W-1:0]),
        .last        (s_tlast),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .feasible    (feasible)
    );

    assign m_tdata = {{(M_TDATA_W-1){1'b0}}, feasible};

endmodule

### design/spc_ctrl.sv
module spc_ctrl
    import spc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  spc_sts_t sts,
    output spc_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EVAL   = 5'b00010,
        ST_PUSH   = 5'b00100,
        ST_REFILL = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    state_t after_item;

    assign after_item = sts.last ? ST_FINISH : ST_IDLE;
    assign s_tready   = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                priority if (sts.failed) begin
                    state_next = after_item;
                end else if (sts.out_of_range) begin
                    cmd.fail   = 1'b1;
                    state_next = after_item;
                end else if (sts.top_hit) begin
                    cmd.pop    = 1'b1;
                    // new top sits in the memory when two or more were stacked
                    state_next = sts.fill_ge2 ? ST_REFILL : after_item;
                end else if (sts.next_le_v) begin
                    if (sts.next_lt_v) begin
                        state_next = ST_PUSH;
                    end else begin
                        cmd.set_next = 1'b1;
                        state_next   = after_item;
                    end
                end else begin
                    cmd.fail   = 1'b1;
                    state_next = after_item;
                end
            end
            ST_PUSH: begin
                if (sts.stack_full) begin
                    cmd.fail   = 1'b1;
                    state_next = after_item;
                end else begin
                    cmd.push = 1'b1;
                    if (sts.push_final) begin
                        state_next = after_item;
                    end
                end
            end
            ST_REFILL: begin
                cmd.refill = 1'b1;
                state_next = after_item;
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### design/spc_datapath.sv
module spc_datapath
    import spc_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [COACH_W-1:0] cfg_wr_data,
    input  logic [COACH_W-1:0] coach,
    input  logic               last,
    input  spc_cmd_t           cmd,
    output spc_sts_t           sts,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               feasible
);

    localparam int unsigned AW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int unsigned FW   = $clog2(MAX_ITEMS + 1);
    localparam int unsigned CapN = (MAX_ITEMS > ((1 << COACH_W) - 1)) ?
                                   ((1 << COACH_W) - 1) : MAX_ITEMS;

    logic [COACH_W-1:0] count_reg;
    logic [COACH_W-1:0] v_reg;
    logic               last_reg;
    logic [NEXT_W-1:0]  next_reg;
    logic [FW-1:0]      fill_reg;
    logic [COACH_W-1:0] top_reg;
    logic               failed_reg;
    logic [COACH_W-1:0] rd_data_reg;
    logic               out_valid_reg;
    logic               out_feasible_reg;

    logic [COACH_W-1:0] mem [MAX_ITEMS];

    logic [COACH_W-1:0] n_eff;
    logic [NEXT_W-1:0]  v_ext;
    logic [NEXT_W-1:0]  v_plus1;
    logic [FW-1:0]      fill_m1;
    logic [FW-1:0]      fill_m2;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic               verdict;

    assign n_eff   = (count_reg > COACH_W'(CapN)) ? COACH_W'(CapN) : count_reg;
    assign v_ext   = {1'b0, v_reg};
    assign v_plus1 = v_ext + NEXT_W'(1);
    assign fill_m1 = fill_reg - FW'(1);
    assign fill_m2 = fill_reg - FW'(2);
    assign wr_addr = fill_m1[AW-1:0];
    assign rd_addr = fill_m2[AW-1:0];
    assign verdict = !failed_reg && (fill_reg == '0) &&
                     (next_reg == ({1'b0, n_eff} + NEXT_W'(1)));

    always_comb begin
        sts.last         = last_reg;
        sts.failed       = failed_reg;
        sts.out_of_range = (v_reg == '0) || (v_reg > n_eff);
        sts.top_hit      = (fill_reg != '0) && (top_reg == v_reg);
        sts.next_le_v    = (next_reg <= v_ext);
        sts.next_lt_v    = (next_reg < v_ext);
        sts.push_final   = ((next_reg + NEXT_W'(1)) == v_ext);
        sts.stack_full   = (fill_reg >= FW'(MAX_ITEMS));
        sts.fill_ge2     = (fill_reg >= FW'(2));
        sts.out_free     = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign feasible = out_feasible_reg;

    // stack body below the cached top; read port tracks the entry under the top
    always_ff @(posedge aclk) begin
        if (cmd.push && (fill_reg != '0)) begin
            mem[wr_addr] <= top_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            v_reg    <= coach;
            last_reg <= last;
        end
        if (cmd.push) begin
            top_reg <= next_reg[COACH_W-1:0];
        end else if (cmd.refill) begin
            top_reg <= rd_data_reg;
        end
        if (cmd.finish) begin
            out_feasible_reg <= verdict;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= COACH_COUNT_RST;
            next_reg      <= NEXT_W'(1);
            fill_reg      <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
            if (cmd.fail) begin
                failed_reg <= 1'b1;
            end
            if (cmd.pop) begin
                fill_reg <= fill_m1;
            end
            if (cmd.set_next) begin
                next_reg <= v_plus1;
            end
            if (cmd.push) begin
                fill_reg <= fill_reg + FW'(1);
                // last push of the run skips over the requested item itself
                next_reg <= sts.push_final ? v_plus1 : (next_reg + NEXT_W'(1));
            end
            if (cmd.finish) begin
                next_reg   <= NEXT_W'(1);
                fill_reg   <= '0;
                failed_reg <= 1'b0;
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### dv/tb_stack_permutation_checker_top.sv
module tb_stack_permutation_checker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spc_pkg::*;

    localparam int unsigned DEPTH        = MAX_ITEMS_DEF;
    localparam int unsigned DRAIN_CYCLES = DEPTH + 40;
    localparam int unsigned HOLD_CYCLES  = 400;

    typedef enum logic [1:0] {FROM_MODEL, SAYS_NO, SAYS_YES} verdict_src_t;
    typedef enum logic {ROW_BEAT, ROW_COUNT} row_kind_t;
    typedef enum logic [1:0] {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [COACH_W-1:0] value;   // coach for a beat, coach_count for a count write
        logic               last;
        verdict_src_t       src;
    } dir_row_t;

    typedef struct packed {
        logic [COACH_W-1:0] count;
        pace_t              pace;
        logic [15:0]        beats;
        logic               hold;    // receiver holds off at phase start
        logic               full;    // one intact order of the whole count
    } rnd_phase_t;

    localparam dir_row_t DIR_ROWS [32] = '{
        '{ROW_BEAT,  11'd0,    1'b1, SAYS_NO},     // zero request
        '{ROW_BEAT,  11'd1025, 1'b1, SAYS_NO},     // just above n
        '{ROW_BEAT,  11'd2047, 1'b1, SAYS_NO},
        '{ROW_BEAT,  11'd1024, 1'b1, SAYS_NO},     // deepest push, then cut short
        '{ROW_COUNT, 11'd3,    1'b0, FROM_MODEL},
        '{ROW_BEAT,  11'd3,    1'b0, FROM_MODEL},
        '{ROW_BEAT,  11'd1,    1'b0, FROM_MODEL},  // buried under 2
        '{ROW_BEAT,  11'd2,    1'b1, SAYS_NO},
        '{ROW_BEAT,  11'd3,    1'b0, FROM_MODEL},
        '{ROW_BEAT,  11'd2,    1'b0, FROM_MODEL},
        '{ROW_BEAT,  11'd1,    1'b1, SAYS_YES},
        '{ROW_BEAT,  11'd1,    1'b0, FROM_MODEL},
        '{ROW_BEAT,  11'd1,    1'b0, FROM_MODEL},  // repeat fails, rest ignored
        '{ROW_BEAT,  11'd2,    1'b0, FROM_MODEL},
        '{ROW_BEAT,  11'd3,    1'b1, SAYS_NO},
        '{ROW_BEAT,  11'd2,    1'b0, FROM_MODEL},
        '{ROW_BEAT,  11'd3,    1'b0, FROM_MODEL},
        '{ROW_BEAT,  11'd1,    1'b0, FROM_MODEL},
        '{ROW_BEAT,  11'd3,    1'b1, FROM_MODEL},  // one request too many
        '{ROW_BEAT,  11'd1,    1'b0, FROM_MODEL},
        '{ROW_BEAT,  11'd2,    1'b0, FROM_MODEL},
        '{ROW_COUNT, 11'd4,    1'b0, FROM_MODEL},  // count changes mid-sequence
        '{ROW_BEAT,  11'd3,    1'b0, FROM_MODEL},
        '{ROW_BEAT,  11'd4,    1'b1, SAYS_YES},
        '{ROW_BEAT,  11'd2,    1'b0, FROM_MODEL},
        '{ROW_BEAT,  11'd1,    1'b1, SAYS_NO},     // short sequence
        '{ROW_COUNT, 11'd1,    1'b0, FROM_MODEL},
        '{ROW_BEAT,  11'd1,    1'b1, SAYS_YES},
        '{ROW_COUNT, 11'd0,    1'b0, FROM_MODEL},
        '{ROW_BEAT,  11'd1,    1'b1, SAYS_NO},
        '{ROW_COUNT, 11'd2047, 1'b0, FROM_MODEL},  // saturates to 1024
        '{ROW_BEAT,  11'd1025, 1'b1, SAYS_NO}
    };

    localparam rnd_phase_t RND_PHASES [13] = '{
        '{11'd5,    PACE_FREE,     16'd20,  1'b0, 1'b0},
        '{11'd1,    PACE_BOTH,     16'd10,  1'b0, 1'b0},
        '{11'd2,    PACE_FREE,     16'd20,  1'b1, 1'b0},
        '{11'd2,    PACE_RECEIVER, 16'd16,  1'b0, 1'b0},
        '{11'd8,    PACE_SENDER,   16'd16,  1'b0, 1'b0},
        '{11'd0,    PACE_FREE,     16'd6,   1'b0, 1'b0},
        '{11'd3,    PACE_BOTH,     16'd16,  1'b0, 1'b0},
        '{11'd16,   PACE_BOTH,     16'd24,  1'b0, 1'b0},
        '{11'd40,   PACE_FREE,     16'd30,  1'b0, 1'b0},
        '{11'd4,    PACE_RECEIVER, 16'd12,  1'b0, 1'b0},
        '{11'd24,   PACE_SENDER,   16'd20,  1'b0, 1'b0},
        '{11'd2047, PACE_FREE,     16'd0,   1'b0, 1'b1},
        '{11'd12,   PACE_BOTH,     16'd12,  1'b0, 1'b0}
    };

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [COACH_W-1:0]   cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tlast     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // siding predictor state
    logic [COACH_W-1:0] siding_count  = COACH_COUNT_RST;
    int unsigned        siding_next   = 1;
    int unsigned        siding_fill   = 0;
    bit                 siding_failed = 1'b0;
    int unsigned        siding_stack [DEPTH];

    bit                 verdict_q [$];
    logic [COACH_W-1:0] order_q [$];
    bit                 want_feasible;

    int errors         = 0;
    int beats_sent     = 0;
    int verdicts_seen  = 0;
    int yes_seen       = 0;
    int counts_written = 0;
    int idle_pct       = 0;
    int stall_pct      = 0;
    int hold_asked     = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    stack_permutation_checker_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int unsigned coaches_in_use(logic [COACH_W-1:0] count);
        return (count > DEPTH) ? DEPTH : count;
    endfunction

    // one request through the siding; verdict_due only on the last beat
    task automatic siding_step(input logic [COACH_W-1:0] coach, input bit last,
                               output bit verdict_due, output bit feasible);
        int unsigned n;
        int unsigned v;
        n = coaches_in_use(siding_count);
        v = coach;
        verdict_due = last;
        feasible = 1'b0;
        if (!siding_failed) begin
            if (v == 0 || v > n) begin
                siding_failed = 1'b1;
            end else if (siding_fill > 0 && siding_stack[siding_fill-1] == v) begin
                siding_fill--;
            end else if (siding_next <= v) begin
                while (siding_next < v && !siding_failed) begin
                    if (siding_fill >= DEPTH) begin
                        siding_failed = 1'b1;
                    end else begin
                        siding_stack[siding_fill] = siding_next;
                        siding_fill++;
                        siding_next++;
                    end
                end
                if (!siding_failed)
                    siding_next = v + 1;
            end else begin
                siding_failed = 1'b1;
            end
        end
        if (last) begin
            feasible = !siding_failed && siding_fill == 0 && siding_next == n + 1;
            siding_next   = 1;
            siding_fill   = 0;
            siding_failed = 1'b0;
        end
    endtask

    task automatic send_beat(input logic [COACH_W-1:0] coach, input bit last,
                             input verdict_src_t src);
        bit due;
        bit ok;
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(coach);
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        siding_step(coach, last, due, ok);
        if (due) begin
            case (src)
                SAYS_YES: verdict_q.push_back(1'b1);
                SAYS_NO:  verdict_q.push_back(1'b0);
                default:  verdict_q.push_back(ok);
            endcase
        end
    endtask

    // wait for the block to go quiet, then write coach_count
    task automatic set_count(input logic [COACH_W-1:0] count);
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        siding_count  = count;
        counts_written++;
    endtask

    // a reachable leaving order of 1..n, then maybe broken
    task automatic make_order(input int unsigned n, input bit intact);
        int unsigned        nxt;
        int unsigned        i;
        int unsigned        j;
        int unsigned        k;
        int unsigned        pick;
        logic [COACH_W-1:0] held [$];
        logic [COACH_W-1:0] tmp;
        nxt = 1;
        order_q.delete();
        while (order_q.size() < n) begin
            if (held.size() > 0 && (nxt > n || $urandom_range(0, 1) == 1)) begin
                order_q.push_back(held.pop_back());
            end else begin
                held.push_back(COACH_W'(nxt));
                nxt++;
            end
        end
        pick = intact ? 0 : $urandom_range(0, 99);
        if (!intact && (pick >= 90 || n == 0)) begin
            order_q.delete();
            k = $urandom_range(1, 6);
            repeat (k) begin
                if ($urandom_range(0, 1) == 1)
                    order_q.push_back(COACH_W'($urandom_range(0, 2047)));
                else
                    order_q.push_back(COACH_W'($urandom_range(0, n + 1)));
            end
        end else if (pick >= 84) begin
            i = $urandom_range(0, n - 1);
            order_q[i] = ($urandom_range(0, 1) == 1) ? COACH_W'(0)
                                                      : COACH_W'($urandom_range(n + 1, 2047));
        end else if (pick >= 78) begin
            order_q.push_back(order_q[$urandom_range(0, n - 1)]);
        end else if (pick >= 72 && n > 1) begin
            k = $urandom_range(1, n - 1);
            repeat (k) void'(order_q.pop_back());
        end else if (pick >= 65 && n > 1) begin
            i = $urandom_range(0, n - 1);
            j = $urandom_range(0, n - 1);
            tmp        = order_q[i];
            order_q[i] = order_q[j];
            order_q[j] = tmp;
        end
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                $error("feasible: expected no result, actual %0d", m_tdata[0]);
                errors++;
            end else begin
                want_feasible = verdict_q.pop_front();
                verdicts_seen++;
                if (m_tdata[0] !== want_feasible) begin
                    $error("feasible: expected %0d, actual %0d", want_feasible, m_tdata[0]);
                    errors++;
                end else if (want_feasible) begin
                    yes_seen++;
                end
            end
        end
    end

    initial begin
        dir_row_t    row;
        rnd_phase_t  ph;
        int unsigned sent;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < $size(DIR_ROWS); r++) begin
            row = DIR_ROWS[r];
            if (row.kind == ROW_COUNT)
                set_count(row.value);
            else
                send_beat(row.value, row.last, row.src);
        end

        for (int p = 0; p < $size(RND_PHASES); p++) begin
            ph = RND_PHASES[p];
            set_count(ph.count);
            case (ph.pace)
                PACE_SENDER:   begin idle_pct = 87; stall_pct = 0;  end
                PACE_RECEIVER: begin idle_pct = 0;  stall_pct = 87; end
                PACE_BOTH:     begin idle_pct = 13; stall_pct = 13; end
                default:       begin idle_pct = 0;  stall_pct = 0;  end
            endcase
            if (ph.hold)
                hold_asked++;
            sent = 0;
            do begin
                make_order(coaches_in_use(ph.count), ph.full);
                for (int i = 0; i < order_q.size(); i++)
                    send_beat(order_q[i], i == order_q.size() - 1, FROM_MODEL);
                sent += order_q.size();
            end while (!ph.full && sent < ph.beats);
        end

        s_tvalid <= 1'b0;
        stall_pct = 0;
        while (verdict_q.size() != 0)
            @(posedge aclk);
        repeat (64) @(posedge aclk);

        $display("Sent %0d request beats over %0d coach-count writes (0, 1 and 2047 included).",
                 beats_sent, counts_written);
        $display("Checked %0d verdicts, %0d of them feasible.", verdicts_seen, yes_seen);
        if (errors == 0)
            $display("PASS stack_permutation_checker_top");
        else
            $display("FAIL stack_permutation_checker_top");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("FAIL stack_permutation_checker_top");
        $finish;
    end

endmodule
